/* rtl/frma_pkg.sv */
// ----------------------------------------------------------------------------
// frma_pkg
// Shared widths, reset values and default sizes for the frame rate meter.
// ----------------------------------------------------------------------------
package frma_pkg;

	localparam int TICK_W = 24;
	localparam int RATE_W = 16;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);

	localparam int WINDOW_LEN_DEF  = 64;
	localparam int HISTORY_LEN_DEF = 128;
	localparam int DECIMATE_DEF    = 8;

endpackage

/* rtl/frma_ram.sv */
// ----------------------------------------------------------------------------
// frma_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module frma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/frma_div.sv */
// ----------------------------------------------------------------------------
// frma_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frma_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// shift in the next numerator bit, subtract when it fits
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/frame_rate_moving_average.sv */
// One frame duration goes in, one result comes out. When the window is full, the time from
// one accepted item to the next is set by the bit-serial divider that forms
// (2*N*tick_rate + sum) / (2*sum), with NUM_W = 26 + log2(WINDOW_LEN). While the window is
// still filling, the divider is skipped. The window lives in a RAM read at accept and
// written back in the next cycle, so one item is in flight at a time; the next item is
// taken while the previous result waits in the output register. No clearing
// pass is needed after reset: the fill count masks entries not yet written.
// ----------------------------------------------------------------------------
// frame_rate_moving_average
// Moving-average frame rate meter with decimated history ring.
// ----------------------------------------------------------------------------
module frame_rate_moving_average #(
	parameter int WINDOW_LEN  = frma_pkg::WINDOW_LEN_DEF,
	parameter int HISTORY_LEN = frma_pkg::HISTORY_LEN_DEF,
	parameter int DECIMATE    = frma_pkg::DECIMATE_DEF,
	localparam int HIST_AW    = $clog2(HISTORY_LEN)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [frma_pkg::TICK_W-1:0] tick_rate,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [frma_pkg::TICK_W-1:0] elapsed_ticks,
	// results
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ready_res,
	output logic [frma_pkg::RATE_W-1:0] frames_per_second,
	output logic                        history_written,
	output logic [HIST_AW-1:0]          history_slot
);

	localparam int TW     = frma_pkg::TICK_W;
	localparam int RW     = frma_pkg::RATE_W;
	localparam int WIN_AW = $clog2(WINDOW_LEN);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = TW + WIN_AW;
	localparam int NUM_W  = TW + 2 + WIN_AW;
	localparam int DEN_W  = SUM_W + 1;
	localparam int DEC_W  = (DECIMATE > 1) ? $clog2(DECIMATE) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_RES  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [TW-1:0]     tick_q;
	logic [TW-1:0]     e_q;
	logic [WIN_AW-1:0] ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DEC_W-1:0]  dec_q;
	logic [HIST_AW-1:0] hist_ptr_q;
	logic              rdy_q;
	logic [NUM_W-1:0]  prod_q;

	logic              out_valid_q;
	logic              ready_q;
	logic [RW-1:0]     fps_q;
	logic              hw_q;
	logic [HIST_AW-1:0] slot_q;

	logic              accept;
	logic              filled;
	logic [TW-1:0]     old_e;
	logic [TW-1:0]     win_rd_data;
	logic              div_start;
	logic              div_done;
	logic [NUM_W-1:0]  quotient;
	logic [RW-1:0]     fps;
	logic              load;
	logic              hist_we;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign filled    = (fill_q == FILL_W'(WINDOW_LEN));

	// entries not yet written read as zero
	assign old_e = filled ? win_rd_data : '0;

	frma_ram #(
		.WIDTH (TW),
		.DEPTH (WINDOW_LEN)
	) u_window (
		.clk     (clk),
		.wr_en   (state_q == ST_UPD),
		.wr_addr (ptr_q),
		.wr_data (e_q),
		.rd_en   (accept),
		.rd_addr (ptr_q),
		.rd_data (win_rd_data)
	);

	assign div_start = (state_q == ST_PREP);

	// a zero sum makes every quotient bit one, which saturates below
	frma_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (prod_q + NUM_W'(sum_q)),
		.den      ({sum_q, 1'b0}),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (!rdy_q) begin
			fps = '0;
		end else if (quotient[NUM_W-1:RW] != '0) begin
			fps = frma_pkg::RATE_MAX;
		end else begin
			fps = quotient[RW-1:0];
		end
	end

	assign load    = (state_q == ST_RES) && (!out_valid_q || !out_stall);
	assign hist_we = load && rdy_q && (dec_q == '0);

	frma_ram #(
		.WIDTH (RW),
		.DEPTH (HISTORY_LEN)
	) u_history (
		.clk     (clk),
		.wr_en   (hist_we),
		.wr_addr (hist_ptr_q),
		.wr_data (fps),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= frma_pkg::TICK_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_q <= tick_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			dec_q      <= '0;
			hist_ptr_q <= '0;
			rdy_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q <= sum_q - SUM_W'(old_e) + SUM_W'(e_q);
					ptr_q <= (ptr_q == WIN_AW'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
					rdy_q <= filled;
					if (filled) begin
						state_q <= ST_PREP;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_RES;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (load) begin
						state_q <= ST_IDLE;
						if (rdy_q) begin
							dec_q <= (dec_q == DEC_W'(DECIMATE - 1)) ? '0 : dec_q + 1'b1;
						end
						if (hist_we) begin
							hist_ptr_q <= (hist_ptr_q == HIST_AW'(HISTORY_LEN - 1)) ?
								'0 : hist_ptr_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and numerator product, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= elapsed_ticks;
		end
		if (state_q == ST_UPD) begin
			prod_q <= NUM_W'(tick_q) * NUM_W'(2 * WINDOW_LEN);
		end
	end

	// output register: a finished result waits here for its transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ready_q <= rdy_q;
			fps_q   <= fps;
			hw_q    <= hist_we;
			slot_q  <= hist_we ? hist_ptr_q : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign ready_res         = ready_q;
	assign frames_per_second = fps_q;
	assign history_written   = hw_q;
	assign history_slot      = slot_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_LEN))
		else $error("fill count beyond window length");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= WIN_AW'(WINDOW_LEN - 1))
		else $error("window pointer out of range");

	a_hist_ready: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> (rdy_q && filled))
		else $error("history written for a result that is not ready");

	a_out_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RES))
		else $error("result presented without a finished item");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_RES))
		else $error("divider wait left to an unexpected state");

endmodule
